// ----- hdl/dcbc_pkg.sv -----
package dcbc_pkg;

  localparam logic [15:0] CRC_POLY = 16'h8005;
  localparam logic [15:0] CRC_INIT = 16'h0000;

  // Control for one CRC update in the core
  typedef struct packed {
    logic fire;
    logic last_byte;
  } step_ctl_t;

  // One finished block check
  typedef struct packed {
    logic        crc_ok;
    logic [15:0] crc_plain;
    logic [15:0] crc_reflected;
  } crc_res_t;

  // Reverse the bit order of a byte
  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7 - i];
    end
    return r;
  endfunction

  // Reverse the bit order of a 16-bit word
  function automatic logic [15:0] rev16(input logic [15:0] v);
    logic [15:0] r;
    for (int i = 0; i < 16; i++) begin
      r[i] = v[15 - i];
    end
    return r;
  endfunction

  // Shift one byte MSB-first through a CRC-16 register
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] crc;
    logic        fb;
    crc = crc_in;
    for (int i = 0; i < 8; i++) begin
      fb  = crc[15] ^ b[7 - i];
      crc = {crc[14:0], 1'b0};
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

endpackage

// ----- hdl/dcbc_if.sv -----
interface dcbc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [15:0] expected_crc;

  modport source (output valid, output data_byte, output last_byte, output expected_crc,
                  input ready);
  modport sink (input valid, input data_byte, input last_byte, input expected_crc,
                output ready);
endinterface

interface dcbc_out_if;
  logic        valid;
  logic        ready;
  logic        crc_ok;
  logic [15:0] crc_plain;
  logic [15:0] crc_reflected;

  modport source (output valid, output crc_ok, output crc_plain, output crc_reflected,
                  input ready);
  modport sink (input valid, input crc_ok, input crc_plain, input crc_reflected,
                output ready);
endinterface

// ----- hdl/dual_crc16_block_check.sv -----
// Checks a block of bytes, one byte per beat, against an expected CRC under two
// CRC-16 variants at once (poly 0x8005, init 0): the plain MSB-first form (UMTS) and the
// reflected form (ARC). The beat flagged last_byte closes the block: it yields one
// result beat with both CRCs and crc_ok, set when either equals expected_crc, and
// both CRCs restart at zero. Other beats yield no result. The block takes one byte per
// cycle, back to back, while no last byte waits on a stalled result; the rate is set
// by the CRC state registers, which fold a whole byte (eight unrolled bit steps) each
// cycle. A last byte is held in the input register, then the result register loads
// when it is consumed, and the result is on out_ch from that load on. A stalled
// result holds back only the next last byte; other bytes keep flowing. expected_crc
// is only looked at on the last byte.
module dual_crc16_block_check (
  input  logic             clk,
  input  logic             rst_n,
  dcbc_in_if.sink          in_ch,
  dcbc_out_if.source       out_ch
);

  // Input register
  logic        in_vld_r, in_vld_nxt;
  logic [7:0]  in_byte_r;
  logic        in_last_r;
  logic [15:0] in_exp_r;

  // Result register
  logic               out_vld_r, out_vld_nxt;
  dcbc_pkg::crc_res_t out_res_r;
  dcbc_pkg::crc_res_t res;

  dcbc_pkg::step_ctl_t ctl;
  logic                out_free;
  logic                in_take;

  // Consume a held beat when it needs no result slot or the slot frees up
  assign out_free      = !out_vld_r || out_ch.ready;
  assign ctl.fire      = in_vld_r && (!in_last_r || out_free);
  assign ctl.last_byte = in_last_r;
  assign in_ch.ready   = !in_vld_r || ctl.fire;
  assign in_take       = in_ch.valid && in_ch.ready;

  dcbc_crc_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .data_byte    (in_byte_r),
    .expected_crc (in_exp_r),
    .res          (res)
  );

  // Hold or refill the input register
  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_ch.ready) begin
      in_vld_nxt = in_ch.valid;
    end
  end

  // Load a result on a closing beat, drop it once taken
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (ctl.fire && ctl.last_byte) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_ch.data_byte;
      in_last_r <= in_ch.last_byte;
      in_exp_r  <= in_ch.expected_crc;
    end
    if (ctl.fire && ctl.last_byte) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.crc_ok        = out_res_r.crc_ok;
  assign out_ch.crc_plain     = out_res_r.crc_plain;
  assign out_ch.crc_reflected = out_res_r.crc_reflected;

endmodule

// ----- hdl/dcbc_crc_core.sv -----
module dcbc_crc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  dcbc_pkg::step_ctl_t ctl,
  input  logic [7:0]          data_byte,
  input  logic [15:0]         expected_crc,
  output dcbc_pkg::crc_res_t  res
);

  logic [15:0] plain_r, plain_nxt;
  logic [15:0] refl_r, refl_nxt;
  logic [15:0] plain_upd, refl_upd, refl_out;

  // Fold the byte into both running CRCs
  assign plain_upd = dcbc_pkg::crc_byte(plain_r, data_byte);
  assign refl_upd  = dcbc_pkg::crc_byte(refl_r, dcbc_pkg::rev8(data_byte));
  assign refl_out  = dcbc_pkg::rev16(refl_upd);

  // Result for the closing beat of a block
  always_comb begin
    res.crc_plain     = plain_upd;
    res.crc_reflected = refl_out;
    res.crc_ok        = (plain_upd == expected_crc) || (refl_out == expected_crc);
  end

  // Advance on each beat, restart after the last one
  always_comb begin
    plain_nxt = plain_r;
    refl_nxt  = refl_r;
    if (ctl.fire) begin
      if (ctl.last_byte) begin
        plain_nxt = dcbc_pkg::CRC_INIT;
        refl_nxt  = dcbc_pkg::CRC_INIT;
      end else begin
        plain_nxt = plain_upd;
        refl_nxt  = refl_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plain_r <= dcbc_pkg::CRC_INIT;
      refl_r  <= dcbc_pkg::CRC_INIT;
    end else begin
      plain_r <= plain_nxt;
      refl_r  <= refl_nxt;
    end
  end

endmodule
